// ----- rtl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg: shared definitions for the 3x3 median filter
// Geometry limits, register indexes, stage side-band and the bit counter
// used by the rank-select median.
// ----------------------------------------------------------------------------
package mf3_pkg;

	localparam int MAX_COLUMNS = 512;
	localparam int MAX_ROWS    = 4096;
	localparam int PIXEL_BITS  = 8;

	localparam int COL_BITS      = $clog2(MAX_COLUMNS);
	localparam int ROW_BITS      = $clog2(MAX_ROWS);
	localparam int COLS_CFG_BITS = 10;
	localparam int ROWS_CFG_BITS = 13;
	localparam int CFG_DATA_BITS = ROWS_CFG_BITS;

	localparam int WIN_SIZE   = 9;
	localparam int WIN_MEDIAN = 4;
	localparam int RANK_BITS  = $clog2(WIN_SIZE + 1);

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_FRAME_COLUMNS = 1'b0,
		REG_FRAME_ROWS    = 1'b1
	} cfg_reg_t;

	// per-output side-band carried down the pipeline
	typedef struct packed {
		logic interior;
		logic last;
	} out_meta_t;

	typedef logic [WIN_SIZE-1:0][PIXEL_BITS-1:0] window_t;

	function automatic logic [RANK_BITS-1:0] count_ones(input logic [WIN_SIZE-1:0] v);
		logic [RANK_BITS-1:0] n;
		n = '0;
		for (int k = 0; k < WIN_SIZE; k++) begin
			n = n + RANK_BITS'(v[k]);
		end
		return n;
	endfunction

endpackage

// ----- rtl/median_filter_3x3_core.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3_core: 3x3 median filter over a raster pixel stream
// Column-addressed line store (two rows of history per entry) feeds a 3x3
// window; interior positions get the rank-4 value, borders pass through.
// ----------------------------------------------------------------------------
// Throughput: one beat per clock unless the output stalls, set by the
//   single read-modify-write line store port (read at accept, write back as
//   the beat leaves stage one). Registers: stage one, window, stage three,
//   output; the stream lags by one row plus one pixel.
// Reset: arst_n clears counters, window and pipeline valids; geometry returns
//   to 512 x 512. Line store contents stay undefined until written.
module median_filter_3x3_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [mf3_pkg::PIXEL_BITS-1:0]        s_tdata,   // [7:0] pixel
	input  logic                                  s_tuser,   // [0] mode (1 = drain)
	// output stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [mf3_pkg::PIXEL_BITS-1:0]        m_tdata,   // [7:0] pixel_out
	output logic                                  m_tlast,   // frame_end
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  mf3_pkg::cfg_reg_t                     cfg_index,
	input  logic [mf3_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import mf3_pkg::*;

	localparam int PB = PIXEL_BITS;

	// geometry, clamped on write
	logic [COLS_CFG_BITS-1:0] cols_q;
	logic [ROWS_CFG_BITS-1:0] rows_q;

	// frame counters
	logic [COL_BITS-1:0] in_col_q, out_col_q;
	logic [ROW_BITS-1:0] in_row_q, out_row_q;
	logic                done_q;

	// line store: {two rows back, one row back} per column
	logic [2*PB-1:0] mem [MAX_COLUMNS];
	logic [2*PB-1:0] rd_q;
	logic            mem_rd_en, mem_wr_en;

	// pipeline
	logic                v_s1, emit_s1;
	logic [COL_BITS-1:0] col_s1;
	logic [PB-1:0]       value_s1;
	out_meta_t           meta_s1;

	logic      v_s2;
	out_meta_t meta_s2;
	window_t   window_q;

	logic                                 v_s3;
	out_meta_t                            meta_s3;
	window_t                              win_s3;
	logic [WIN_SIZE-1:0][WIN_SIZE-1:0]    beats_s3;

	logic          out_valid_q, out_last_q;
	logic [PB-1:0] out_data_q;

	logic en1, en2, en3, en_out;

	// accept-side decode
	logic                     take, active, emit;
	logic [PB-1:0]            value;
	logic [COLS_CFG_BITS-1:0] col_inc, ocol_inc;
	logic [ROWS_CFG_BITS-1:0] row_inc, orow_inc;
	logic                     col_wrap, row_last, ocol_wrap;
	out_meta_t                meta_now;

	logic [WIN_SIZE-1:0][WIN_SIZE-1:0] beats;
	logic [PB-1:0]                     median;

	// stall chain: each stage moves when the next one is free or moving
	assign en_out    = !out_valid_q || m_tready;
	assign en3       = !v_s3 || en_out;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign s_tready  = en1;
	assign cfg_ready = 1'b1;

	// decode the accepted beat against the frame counters
	always_comb begin
		take     = s_tvalid && s_tready;
		active   = take && (done_q || !s_tuser);
		value    = done_q ? '0 : s_tdata;
		emit     = done_q || (in_row_q >= ROW_BITS'(2)) ||
		           (in_row_q == ROW_BITS'(1) && in_col_q != '0);
		col_inc  = COLS_CFG_BITS'(in_col_q) + COLS_CFG_BITS'(1);
		col_wrap = col_inc >= cols_q;
		row_inc  = ROWS_CFG_BITS'(in_row_q) + ROWS_CFG_BITS'(1);
		row_last = row_inc >= rows_q;
		ocol_inc = COLS_CFG_BITS'(out_col_q) + COLS_CFG_BITS'(1);
		orow_inc = ROWS_CFG_BITS'(out_row_q) + ROWS_CFG_BITS'(1);
		ocol_wrap = ocol_inc >= cols_q;
		meta_now.interior = (out_row_q != '0) && (orow_inc < rows_q) &&
		                    (out_col_q != '0) && (ocol_inc < cols_q);
		meta_now.last     = (orow_inc >= rows_q) && ocol_wrap;
	end

	assign mem_rd_en = active;
	assign mem_wr_en = v_s1 && en2;

	// take configuration writes, clamp to the supported range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLS_CFG_BITS'(MAX_COLUMNS);
			rows_q <= ROWS_CFG_BITS'(512);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_COLUMNS: begin
					if (cfg_data[COLS_CFG_BITS-1:0] < COLS_CFG_BITS'(3))
						cols_q <= COLS_CFG_BITS'(3);
					else if (cfg_data[COLS_CFG_BITS-1:0] > COLS_CFG_BITS'(MAX_COLUMNS))
						cols_q <= COLS_CFG_BITS'(MAX_COLUMNS);
					else
						cols_q <= cfg_data[COLS_CFG_BITS-1:0];
				end
				REG_FRAME_ROWS: begin
					if (cfg_data < ROWS_CFG_BITS'(3))
						rows_q <= ROWS_CFG_BITS'(3);
					else if (cfg_data > ROWS_CFG_BITS'(MAX_ROWS))
						rows_q <= ROWS_CFG_BITS'(MAX_ROWS);
					else
						rows_q <= cfg_data;
				end
			endcase
		end
	end

	// advance frame counters on each beat that does work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			done_q    <= 1'b0;
		end else if (active) begin
			if (emit && meta_now.last) begin
				// final output of the frame: rewind everything
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				done_q    <= 1'b0;
			end else begin
				if (col_wrap) begin
					in_col_q <= '0;
					if (!done_q) begin
						if (row_last)
							done_q <= 1'b1;
						else
							in_row_q <= in_row_q + ROW_BITS'(1);
					end
				end else begin
					in_col_q <= col_inc[COL_BITS-1:0];
				end
				if (emit) begin
					if (ocol_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_BITS'(1);
					end else begin
						out_col_q <= ocol_inc[COL_BITS-1:0];
					end
				end
			end
		end
	end

	// line store: read at accept, write back the shifted column from stage one;
	// a frame restart reads column zero as it is written back, so forward it
	always_ff @(posedge clk) begin
		if (mem_rd_en) begin
			if (mem_wr_en && in_col_q == col_s1)
				rd_q <= {rd_q[PB-1:0], value_s1};
			else
				rd_q <= mem[in_col_q];
		end
		if (mem_wr_en)
			mem[col_s1] <= {rd_q[PB-1:0], value_s1};
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= active;
			if (en2)
				v_s2 <= v_s1 && emit_s1;
			if (en3)
				v_s3 <= v_s2;
			if (en_out)
				out_valid_q <= v_s3;
		end
	end

	// shift the window by one column as each beat leaves stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (mem_wr_en) begin
			window_q[5:0] <= window_q[8:3];
			window_q[6]   <= rd_q[2*PB-1:PB];
			window_q[7]   <= rd_q[PB-1:0];
			window_q[8]   <= value_s1;
		end
	end

	// pairwise order: bit j of row i set when element j ranks below element i
	always_comb begin
		for (int i = 0; i < WIN_SIZE; i++) begin
			for (int j = 0; j < WIN_SIZE; j++) begin
				if (j < i)
					beats[i][j] = window_q[j] <= window_q[i];
				else if (j > i)
					beats[i][j] = window_q[j] < window_q[i];
				else
					beats[i][j] = 1'b0;
			end
		end
	end

	// pick the element whose rank is the middle one
	always_comb begin
		median = '0;
		for (int i = 0; i < WIN_SIZE; i++) begin
			if (count_ones(beats_s3[i]) == RANK_BITS'(WIN_MEDIAN))
				median = median | win_s3[i];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en1 && active) begin
			col_s1   <= in_col_q;
			value_s1 <= value;
			emit_s1  <= emit;
			meta_s1  <= meta_now;
		end
		if (mem_wr_en)
			meta_s2 <= meta_s1;
		if (en3 && v_s2) begin
			meta_s3  <= meta_s2;
			win_s3   <= window_q;
			beats_s3 <= beats;
		end
		if (en_out && v_s3) begin
			out_data_q <= meta_s3.interior ? median : win_s3[WIN_MEDIAN];
			out_last_q <= meta_s3.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// a read meets the write-back of its own column only on a frame restart
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_rd_en && mem_wr_en && in_col_q == col_s1) |-> (in_col_q == '0))
		else $error("line store read and write hit the same column mid-frame");

	// the final output of a frame rewinds every counter
	assert property (@(posedge clk) disable iff (!arst_n)
		(active && emit && meta_now.last) |=>
		(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 &&
		 out_row_q == '0 && !done_q))
		else $error("frame counters not rewound after last output");

	// input stalls only when every stage is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && out_valid_q && !m_tready))
		else $error("input stalled with room in the pipeline");

endmodule

// ----- verif/tb_median_filter_3x3_core.sv -----
// ----------------------------------------------------------------------------
// tb_median_filter_3x3_core: self-checking bench for the 3x3 median filter
// Streams whole frames of pixels and drain ticks into the core across many
// frame geometries, including clamped and widest ones. A local pixel-exact
// filter computes the expected beats not given by the script. Both stream
// sides idle at random; the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mf3_pkg::*;

	localparam int CYCLE_LIMIT    = 2_000_000;
	localparam int RANDOM_BEATS   = 1500;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 20;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_AT_RESULT = 400;
	localparam int SCRIPT_LEN     = 21;

	typedef enum logic {
		MODE_PIXEL = 1'b0,
		MODE_DRAIN = 1'b1
	} beat_mode_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel_out;
		logic                  frame_end;
	} filtered_t;

	// one directed beat; result is used only when typed is set
	typedef struct packed {
		beat_mode_t            mode;
		logic [PIXEL_BITS-1:0] pixel;
		logic                  typed;
		logic                  gives;
		filtered_t             result;
	} script_row_t;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [PIXEL_BITS-1:0]    s_tdata   = '0;
	logic                     s_tuser   = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [PIXEL_BITS-1:0]    m_tdata;
	logic                     m_tlast;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	cfg_reg_t                 cfg_index = REG_FRAME_COLUMNS;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	median_filter_3x3_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// filter model state, starting from the reset values
	logic [COLS_CFG_BITS-1:0] geo_cols = 10'd512;
	logic [ROWS_CFG_BITS-1:0] geo_rows = 13'd512;
	logic [PIXEL_BITS-1:0]    line_upper [MAX_COLUMNS];
	logic [PIXEL_BITS-1:0]    line_lower [MAX_COLUMNS];
	logic [PIXEL_BITS-1:0]    window [WIN_SIZE];
	int unsigned              in_col  = 0;
	int unsigned              in_row  = 0;
	int unsigned              out_col = 0;
	int unsigned              out_row = 0;
	logic                     in_done = 1'b0;

	filtered_t   pending_pixels [$];
	script_row_t script [SCRIPT_LEN];
	logic        frame_closed  = 1'b0;
	int          beats_counted = 0;
	int          mismatches    = 0;
	int          tx_idle_pct   = 20;
	int          rx_idle_pct   = 20;
	int          rx_hold       = 0;
	int          rx_count      = 0;
	int          cycles        = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < MAX_COLUMNS; i++) begin
			line_upper[i] = '0;
			line_lower[i] = '0;
		end
		for (int i = 0; i < WIN_SIZE; i++) begin
			window[i] = '0;
		end
	end

	// hard stop if the run hangs
	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int unsigned eff_cols();
		if (geo_cols < 3) return 3;
		if (geo_cols > MAX_COLUMNS) return MAX_COLUMNS;
		return geo_cols;
	endfunction

	function automatic int unsigned eff_rows();
		if (geo_rows < 3) return 3;
		if (geo_rows > MAX_ROWS) return MAX_ROWS;
		return geo_rows;
	endfunction

	// advance the filter by one accepted beat; returns 1 when it yields a pixel
	function automatic logic filter_beat(input beat_mode_t mode, input logic [7:0] pix,
			output filtered_t res);
		int unsigned cols, rows, col;
		int i, j;
		logic [PIXEL_BITS-1:0] val, top, mid, t;
		logic [PIXEL_BITS-1:0] srt [WIN_SIZE];
		logic emit, interior, frame_end;
		cols = eff_cols();
		rows = eff_rows();
		res = '0;
		// drain before the frame is complete is dropped
		if (!in_done && mode == MODE_DRAIN) return 1'b0;
		// after the last pixel every beat is a drain
		val = in_done ? '0 : pix;
		col = in_col % MAX_COLUMNS;
		top = line_upper[col];
		mid = line_lower[col];
		line_upper[col] = mid;
		line_lower[col] = val;
		for (i = 0; i < 6; i++) begin
			window[i] = window[i + 3];
		end
		window[6] = top;
		window[7] = mid;
		window[8] = val;
		emit = in_done || in_row >= 2 || (in_row == 1 && col >= 1);
		if (col + 1 >= cols) begin
			in_col = 0;
			if (!in_done) begin
				if (in_row + 1 >= rows) in_done = 1'b1;
				else in_row++;
			end
		end else begin
			in_col = col + 1;
		end
		if (!emit) return 1'b0;
		interior = out_row >= 1 && out_row + 1 < rows && out_col >= 1 && out_col + 1 < cols;
		if (interior) begin
			// fifth smallest of the nine
			srt = window;
			for (i = 1; i < WIN_SIZE; i++) begin
				t = srt[i];
				j = i - 1;
				while (j >= 0 && srt[j] > t) begin
					srt[j + 1] = srt[j];
					j--;
				end
				srt[j + 1] = t;
			end
			res.pixel_out = srt[WIN_MEDIAN];
		end else begin
			res.pixel_out = window[4];
		end
		frame_end = out_row + 1 >= rows && out_col + 1 >= cols;
		res.frame_end = frame_end;
		// close the frame or move the output position on
		if (frame_end) begin
			in_col  = 0;
			in_row  = 0;
			out_col = 0;
			out_row = 0;
			in_done = 1'b0;
		end else if (out_col + 1 >= cols) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		return 1'b1;
	endfunction

	function automatic int idle_share();
		case ($urandom_range(2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	function automatic logic [7:0] pick_pixel(input int style, input logic [7:0] base);
		case (style)
			0: return 8'($urandom_range(255));
			// narrow band, plenty of ties in the window
			1: return base + 8'($urandom_range(3));
			default: return $urandom_range(1) ? 8'd255 : 8'd0;
		endcase
	endfunction

	// compare one output beat with the oldest pending pixel
	task automatic check_output(input logic [7:0] px, input logic fe);
		filtered_t want;
		rx_count++;
		if (rx_count == HOLD_AT_RESULT) rx_hold = LONG_HOLD;
		if (pending_pixels.size() == 0) begin
			mismatches++;
			$error("unexpected beat: pixel_out %0d, frame_end %0b", px, fe);
			return;
		end
		want = pending_pixels.pop_front();
		if (px !== want.pixel_out) begin
			mismatches++;
			$error("pixel_out: expected %0d, got %0d", want.pixel_out, px);
		end
		if (fe !== want.frame_end) begin
			mismatches++;
			$error("frame_end: expected %0b, got %0b", want.frame_end, fe);
		end
	endtask

	// output side: check accepted beats, then decide ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) check_output(m_tdata, m_tlast);
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
			rx_hold = $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// offer one input beat, wait for acceptance, then predict its output
	task automatic push_beat(input beat_mode_t mode, input logic [7:0] pix,
			input logic typed, input logic gives, input filtered_t given);
		int gap;
		filtered_t got;
		logic made;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= pix;
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		if (mode == MODE_PIXEL || in_done) beats_counted++;
		made = filter_beat(mode, pix, got);
		frame_closed = made && got.frame_end;
		if (typed) begin
			if (gives) pending_pixels.push_back(given);
		end else if (made) begin
			pending_pixels.push_back(got);
		end
	endtask

	task automatic src_rest();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every pending pixel, then let the pipeline empty
	task automatic settle();
		src_rest();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		if (idx == REG_FRAME_COLUMNS) geo_cols = val[COLS_CFG_BITS-1:0];
		else geo_rows = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_geometry(input logic [12:0] cols_val, input logic [12:0] rows_val);
		write_reg(REG_FRAME_COLUMNS, cols_val);
		write_reg(REG_FRAME_ROWS, rows_val);
	endtask

	// finish the current frame: pixels with stray drains, then the tail
	task automatic run_frame(input int style, input logic pause_mid);
		int k, half;
		logic [7:0] base;
		half = eff_cols() * eff_rows() / 2;
		base = 8'($urandom);
		k = 0;
		frame_closed = 1'b0;
		while (!in_done) begin
			if ($urandom_range(99) < 4) push_beat(MODE_DRAIN, 8'($urandom), 1'b0, 1'b0, '0);
			if (pause_mid && k == half) begin
				src_rest();
				while (pending_pixels.size() != 0) @(posedge clk);
			end
			push_beat(MODE_PIXEL, pick_pixel(style, base), 1'b0, 1'b0, '0);
			k++;
		end
		// tail: drains, with the odd late pixel that counts as a drain
		while (!frame_closed)
			push_beat($urandom_range(4) == 0 ? MODE_PIXEL : MODE_DRAIN, 8'($urandom),
				1'b0, 1'b0, '0);
	endtask

	initial begin
		int ph, nfr;
		// 3x3 frame with a cross pattern: borders pass, centre is the median
		script = '{
			'{MODE_DRAIN, 8'd165, 1'b1, 1'b0, '{8'd0,   1'b0}},  // drain before any pixel
			'{MODE_PIXEL, 8'd0,   1'b1, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd255, 1'b1, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd0,   1'b1, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd255, 1'b1, 1'b0, '{8'd0,   1'b0}},
			'{MODE_DRAIN, 8'd99,  1'b1, 1'b0, '{8'd0,   1'b0}},  // mid-frame drain, dropped
			'{MODE_PIXEL, 8'd128, 1'b1, 1'b1, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd255, 1'b1, 1'b1, '{8'd255, 1'b0}},
			'{MODE_PIXEL, 8'd0,   1'b1, 1'b1, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd255, 1'b1, 1'b1, '{8'd255, 1'b0}},
			'{MODE_PIXEL, 8'd0,   1'b1, 1'b1, '{8'd128, 1'b0}},
			'{MODE_PIXEL, 8'd77,  1'b1, 1'b1, '{8'd255, 1'b0}},  // late pixel acts as drain
			'{MODE_DRAIN, 8'd0,   1'b1, 1'b1, '{8'd0,   1'b0}},
			'{MODE_DRAIN, 8'd0,   1'b1, 1'b1, '{8'd255, 1'b0}},
			'{MODE_DRAIN, 8'd0,   1'b1, 1'b1, '{8'd0,   1'b1}},
			// next frame starts straight away
			'{MODE_PIXEL, 8'd200, 1'b0, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd3,   1'b0, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd90,  1'b0, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd17,  1'b0, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd254, 1'b0, 1'b0, '{8'd0,   1'b0}},
			'{MODE_PIXEL, 8'd1,   1'b0, 1'b0, '{8'd0,   1'b0}}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both registers below their floor, so the frame is 3x3
		write_geometry(13'd0, 13'd1);
		for (int r = 0; r < SCRIPT_LEN; r++)
			push_beat(script[r].mode, script[r].pixel, script[r].typed, script[r].gives,
				script[r].result);
		run_frame(0, 1'b0);

		// random geometries, with the widest frame once
		beats_counted = 0;
		ph = 0;
		while (beats_counted < RANDOM_BEATS) begin
			settle();
			tx_idle_pct = idle_share();
			rx_idle_pct = idle_share();
			if (ph == 2) begin
				tx_idle_pct = 5;
				rx_idle_pct = 5;
				write_geometry(13'd1023, 13'd3);
				run_frame(0, 1'b0);
			end else begin
				if ($urandom_range(5) == 0)
					write_geometry(13'($urandom_range(0, 40)), 13'($urandom_range(0, 12)));
				else
					write_geometry(13'($urandom_range(3, 16)), 13'($urandom_range(3, 8)));
				nfr = $urandom_range(1, 3);
				for (int f = 0; f < nfr; f++)
					run_frame($urandom_range(2), ph == 1 && f == 0);
			end
			ph++;
		end

		// closing frames at full rate
		settle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_geometry(13'd5, 13'd4);
		run_frame(0, 1'b0);
		run_frame(1, 1'b0);

		src_rest();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			mismatches++;
			$error("%0d pixels never arrived", pending_pixels.size());
		end
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mf3_pkg.sv
rtl/median_filter_3x3_core.sv
verif/tb_median_filter_3x3_core.sv
